>>> rtl/vrb_pkg.sv
// Shared types and constants of the variable-radius row blur.
package vrb_pkg;

	localparam int QW = 16;
	localparam logic [6:0] WEIGHT_COUNT_RESET = 7'd64;
	localparam logic REQ_WEIGHT = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [5:0]  weight_index;
		logic [15:0] weight_value;
		logic [15:0] in_red;
		logic [15:0] in_green;
		logic [15:0] in_blue;
		logic [15:0] in_alpha;
		logic [7:0]  pixel_radius;
		logic        row_end;
	} req_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [15:0] out_alpha;
		logic        out_last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CTR, S_CTRW, S_STEPW, S_N0, S_N0W, S_TAB, S_TAB1,
		S_TAB2, S_WTW, S_PX, S_PX1, S_PX2, S_NORM, S_OUTW, S_OUT
	} state_t;

endpackage

>>> rtl/variable_radius_symmetric_row_blur.sv
// Top level of the variable-radius symmetric row blur, one horizontal pass.
//
// Usage: the req channel (req_valid, req_stall, req_item) carries two kinds of item.
// A weight item writes one Q0.16 entry of the weight table and gives no result.
// A pixel item pushes one RGBA pixel and its radius into the row window. Results
// lag the input by MAX_RADIUS pixels; the pixel marked row_end flushes every
// pending centre, and the last of those carries out_last. The res channel
// (res_valid, res_stall, res_item) delivers results from an output register.
// cfg_valid/cfg_ready writes weight_count; write it only while the block is idle.
// The shared 16-step divider sets the time of each result: it runs for the table
// step, the start phase, each interpolated weight (not where the table is sampled
// below its first entry) and the four normalising divisions, so the time grows
// with the centre's radius r. req_stall is high from acceptance of a pixel that
// opens a centre (a full window or row_end) until its last result sits in the
// output register.
// Reset: weight_count goes to 64, row position and window pointers clear; the
// weight table holds garbage until loaded. A stalled receiver holds the current
// result and the sequencer waits before loading the next.
module variable_radius_symmetric_row_blur #(
	parameter int MAX_RADIUS     = 32,
	parameter int WEIGHT_ENTRIES = 64,
	parameter int ROW_MAX        = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  vrb_pkg::req_t req_item,
	output logic          res_valid,
	input  logic          res_stall,
	output vrb_pkg::res_t res_item,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_data
);
	import vrb_pkg::*;

	localparam int PIX_LEN = 2 * MAX_RADIUS + 1;
	localparam int RAD_LEN = MAX_RADIUS + 1;
	localparam int PAW     = $clog2(PIX_LEN);
	localparam int RW      = $clog2(MAX_RADIUS + 1);
	localparam int TW      = (WEIGHT_ENTRIES > 2) ? $clog2(WEIGHT_ENTRIES) : 1;
	localparam int WCW     = $clog2(WEIGHT_ENTRIES + 1);
	localparam int PW      = (ROW_MAX > 2) ? $clog2(ROW_MAX) : 1;
	localparam int DW      = $clog2(2 * MAX_RADIUS + 3);
	localparam int KW      = $clog2(WEIGHT_ENTRIES + 1) + 1;
	localparam int NW      = ((WCW > RW) ? WCW : RW) + 2;
	localparam int SUMW    = QW + $clog2(2 * MAX_RADIUS + 2);
	localparam int ACCW    = SUMW + QW;
	localparam int PRW     = QW + DW;

	// control state
	state_t         state_q, state_d;
	logic [6:0]     weight_count_q;
	logic [PW-1:0]  row_pos_q;
	logic [PAW-1:0] pix_head_q;
	logic [RW-1:0]  rad_head_q;
	logic           out_valid_q;

	// working registers of one centre
	logic [63:0]           first_px_q;
	logic                  end_q;
	logic [RW-1:0]         e_q;
	logic [PW-1:0]         c_q;
	logic [RW-1:0]         r_q;
	logic [DW-1:0]         d_q;
	logic [RW-1:0]         i_q;
	logic signed [KW-1:0]  k_q;
	logic [DW-1:0]         f_q;
	logic signed [KW-1:0]  qstep_q;
	logic [DW-1:0]         rstep_q;
	logic [PRW-1:0]        prod_q;
	logic [15:0]           wt_q;
	logic                  first_sel_q;
	logic [ACCW-1:0]       acc_q [4];
	logic [SUMW-1:0]       wsum_q;
	logic [1:0]            ch_q;
	logic [15:0]           chres_q [4];
	res_t                  res_q;

	// memories and their registered read data
	logic [15:0]   wtab_mem [WEIGHT_ENTRIES];
	logic [63:0]   pix_mem [PIX_LEN];
	logic [RW-1:0] rad_mem [RAD_LEN];
	logic [15:0]   wtab_rd_q;
	logic [63:0]   pix_rd_q;
	logic [RW-1:0] rad_rd_q;

	logic           req_acc, pix_acc, wgt_acc;
	logic [63:0]    px_in;
	logic [RW-1:0]  rad_in;
	logic [PAW-1:0] pix_head_nx;
	logic [RW-1:0]  rad_head_nx;
	logic           row_full;
	logic [WCW-1:0] w_act;
	logic [PAW-1:0] pix_off;
	logic [PAW:0]   pdiff;
	logic [PAW-1:0] pix_raddr;
	logic [RW:0]    rdiff;
	logic [RW-1:0]  rad_raddr;
	logic [TW-1:0]  wtab_raddr;
	logic [DW-1:0]  d_new;
	logic signed [NW-1:0] n0;
	logic [63:0]    mac_px;
	logic [15:0]    mac_wt;
	logic [2*QW-1:0] mac_prod [4];
	logic [PRW-1:0] interp_a;
	logic [ACCW-1:0] wnum;
	logic [DW:0]    fsum;
	logic           fwrap;
	logic [1:0]     ch_sel;
	logic           out_free;
	logic           div_start, div_done;
	logic [ACCW-1:0] div_dividend;
	logic [SUMW-1:0] div_divisor;
	logic [QW-1:0]   div_quot;
	logic [SUMW-1:0] div_rem;

	function automatic logic [TW-1:0] tab_idx(input int kk, input int ww);
		if (kk < 0) return '0;
		else if (kk > ww - 1) return TW'(ww - 1);
		else return TW'(kk);
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign pix_acc   = req_acc && (req_item.req_type == REQ_PIXEL);
	assign wgt_acc   = req_acc && (req_item.req_type == REQ_WEIGHT)
		&& (int'(req_item.weight_index) < WEIGHT_ENTRIES);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !res_stall;

	assign px_in  = {req_item.in_alpha, req_item.in_blue, req_item.in_green, req_item.in_red};
	assign rad_in = (int'(req_item.pixel_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS)
		: RW'(req_item.pixel_radius);
	assign pix_head_nx = (pix_head_q == PAW'(PIX_LEN - 1)) ? '0 : pix_head_q + 1'b1;
	assign rad_head_nx = (rad_head_q == RW'(RAD_LEN - 1)) ? '0 : rad_head_q + 1'b1;
	assign row_full    = int'(row_pos_q) >= MAX_RADIUS;

	// clamp the table resolution to what the table holds
	always_comb begin
		if (weight_count_q < 7'd2) w_act = WCW'(2);
		else if (int'(weight_count_q) > WEIGHT_ENTRIES) w_act = WCW'(WEIGHT_ENTRIES);
		else w_act = WCW'(weight_count_q);
	end

	// window offsets back from the newest pixel: e is the centre's distance from it
	always_comb begin
		case (state_q)
			S_CTR:   pix_off = PAW'(e_q);
			S_PX:    pix_off = (e_q > i_q) ? PAW'(e_q - i_q) : '0;
			default: pix_off = PAW'({1'b0, e_q} + {1'b0, i_q});
		endcase
		pdiff     = {1'b0, pix_head_q} - {1'b0, pix_off};
		pix_raddr = pdiff[PAW] ? pdiff[PAW-1:0] + PAW'(PIX_LEN) : pdiff[PAW-1:0];
		rdiff     = {1'b0, rad_head_q} - {1'b0, e_q};
		rad_raddr = rdiff[RW] ? rdiff[RW-1:0] + RW'(RAD_LEN) : rdiff[RW-1:0];
	end

	always_comb begin
		case (state_q)
			S_CTR:   wtab_raddr = '0;
			S_TAB1:  wtab_raddr = tab_idx(int'(k_q) + 1, int'(w_act));
			default: wtab_raddr = tab_idx(int'(k_q), int'(w_act));
		endcase
	end

	// four channel lanes of the multiply-accumulate
	always_comb begin
		mac_px = (state_q == S_PX2 && first_sel_q) ? first_px_q : pix_rd_q;
		mac_wt = (state_q == S_CTRW) ? wtab_rd_q : wt_q;
		for (int ch = 0; ch < 4; ch++) begin
			mac_prod[ch] = mac_px[16*ch +: 16] * mac_wt;
		end
	end

	always_comb begin
		d_new    = DW'(2 * (int'(rad_rd_q) + 1));
		// sample point of the first neighbour: N = 3W - (r+1)
		n0       = NW'({w_act, 1'b0}) + NW'(w_act) - NW'(r_q) - NW'(1);
		interp_a = PRW'(wtab_rd_q) * PRW'(d_q - f_q);
		wnum     = ACCW'(prod_q) + ACCW'(PRW'(wtab_rd_q) * PRW'(f_q)) + ACCW'(d_q >> 1);
		fsum     = {1'b0, f_q} + {1'b0, rstep_q};
		fwrap    = fsum >= {1'b0, d_q};
		ch_sel   = (state_q == S_NORM) ? 2'd0 : ch_q + 2'd1;
	end

	// divider operands and start
	always_comb begin
		div_start    = 1'b0;
		div_dividend = acc_q[ch_sel] + ACCW'(wsum_q >> 1);
		div_divisor  = wsum_q;
		case (state_q)
			S_CTRW: begin
				div_start    = (rad_rd_q != '0);
				div_dividend = ACCW'({w_act, 1'b0});
				div_divisor  = SUMW'(d_new);
			end
			S_N0: begin
				div_start    = !n0[NW-1];
				div_dividend = ACCW'(n0);
				div_divisor  = SUMW'(d_q);
			end
			S_TAB2: begin
				div_start    = 1'b1;
				div_dividend = wnum;
				div_divisor  = SUMW'(d_q);
			end
			S_NORM:  div_start = (wsum_q != '0);
			S_OUTW:  div_start = div_done && (ch_q != 2'd3);
			default: div_start = 1'b0;
		endcase
	end

	vrb_div #(
		.DVW(SUMW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (pix_acc && (req_item.row_end || row_full)) state_d = S_CTR;
			S_CTR:   state_d = S_CTRW;
			S_CTRW:  state_d = (rad_rd_q == '0) ? S_NORM : S_STEPW;
			S_STEPW: if (div_done) state_d = S_N0;
			S_N0:    state_d = n0[NW-1] ? S_TAB : S_N0W;
			S_N0W:   if (div_done) state_d = S_TAB;
			S_TAB:   state_d = S_TAB1;
			S_TAB1:  state_d = (k_q < 0) ? S_PX : S_TAB2;
			S_TAB2:  state_d = S_WTW;
			S_WTW:   if (div_done) state_d = S_PX;
			S_PX:    state_d = S_PX1;
			S_PX1:   state_d = S_PX2;
			S_PX2:   state_d = (i_q == r_q) ? S_NORM : S_TAB;
			S_NORM:  state_d = (wsum_q == '0) ? S_OUT : S_OUTW;
			S_OUTW:  if (div_done && ch_q == 2'd3) state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = (!end_q || e_q == '0) ? S_IDLE : S_CTR;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			weight_count_q <= WEIGHT_COUNT_RESET;
			row_pos_q      <= '0;
			pix_head_q     <= '0;
			rad_head_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) weight_count_q <= cfg_data;
			if (pix_acc) begin
				pix_head_q <= pix_head_nx;
				rad_head_q <= rad_head_nx;
				// saturate an over-long row, restart on its last pixel
				if (req_item.row_end) row_pos_q <= '0;
				else if (int'(row_pos_q) < ROW_MAX - 1) row_pos_q <= row_pos_q + 1'b1;
			end
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (!res_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wtab_rd_q <= wtab_mem[wtab_raddr];
		if (wgt_acc) wtab_mem[TW'(req_item.weight_index)] <= req_item.weight_value;
		pix_rd_q <= pix_mem[pix_raddr];
		rad_rd_q <= rad_mem[rad_raddr];
		if (pix_acc) begin
			pix_mem[pix_head_nx] <= px_in;
			rad_mem[rad_head_nx] <= rad_in;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pix_acc) begin
					if (row_pos_q == '0) first_px_q <= px_in;
					end_q <= req_item.row_end;
					e_q   <= row_full ? RW'(MAX_RADIUS) : RW'(row_pos_q);
					c_q   <= row_full ? row_pos_q - PW'(MAX_RADIUS) : '0;
				end
			end
			S_CTRW: begin
				r_q    <= rad_rd_q;
				d_q    <= d_new;
				i_q    <= RW'(1);
				wsum_q <= SUMW'(wtab_rd_q);
				for (int ch = 0; ch < 4; ch++) acc_q[ch] <= ACCW'(mac_prod[ch]);
			end
			S_STEPW: begin
				if (div_done) begin
					qstep_q <= KW'(div_quot);
					rstep_q <= DW'(div_rem);
				end
			end
			S_N0: begin
				// below the first entry: keep the floor form with k = -1
				if (n0[NW-1]) begin
					k_q <= '1;
					f_q <= DW'(n0 + NW'(d_q));
				end
			end
			S_N0W: begin
				if (div_done) begin
					k_q <= KW'(div_quot);
					f_q <= DW'(div_rem);
				end
			end
			S_TAB1: begin
				if (k_q < 0) wt_q <= wtab_rd_q;
				else prod_q <= interp_a;
			end
			S_WTW: if (div_done) wt_q <= div_quot;
			S_PX1: begin
				for (int ch = 0; ch < 4; ch++) acc_q[ch] <= acc_q[ch] + ACCW'(mac_prod[ch]);
				first_sel_q <= int'(c_q) < int'(i_q);
			end
			S_PX2: begin
				for (int ch = 0; ch < 4; ch++) acc_q[ch] <= acc_q[ch] + ACCW'(mac_prod[ch]);
				wsum_q <= wsum_q + SUMW'({wt_q, 1'b0});
				i_q    <= i_q + 1'b1;
				// advance the sample point by 2W/D
				f_q <= fwrap ? DW'(fsum - {1'b0, d_q}) : fsum[DW-1:0];
				k_q <= fwrap ? k_q + qstep_q + KW'(1) : k_q + qstep_q;
			end
			S_NORM: begin
				ch_q <= 2'd0;
				if (wsum_q == '0) begin
					for (int ch = 0; ch < 4; ch++) chres_q[ch] <= '0;
				end
			end
			S_OUTW: begin
				if (div_done) begin
					chres_q[ch_q] <= div_quot;
					ch_q          <= ch_q + 2'd1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					res_q <= '{out_red: chres_q[0], out_green: chres_q[1],
						out_blue: chres_q[2], out_alpha: chres_q[3],
						out_last: end_q && (e_q == '0)};
					e_q <= e_q - 1'b1;
					c_q <= c_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = out_valid_q;
	assign res_item  = res_q;

	a_frac_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAB) |-> (f_q < d_q))
		else $error("interpolation fraction not below its denominator");

	a_tap_in_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAB) |-> (i_q != '0 && i_q <= r_q))
		else $error("neighbour index outside the centre radius");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_STEPW || state_q == S_N0W || state_q == S_WTW
			|| state_q == S_OUTW))
		else $error("divider finished with no state waiting for it");

	a_centre_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CTR) |-> (int'(e_q) <= MAX_RADIUS))
		else $error("centre outside the pending window");

endmodule

>>> rtl/vrb_div.sv
// Restoring divider giving a 16-bit quotient, one quotient bit per cycle.
module vrb_div #(
	parameter int DVW = 23
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DVW+vrb_pkg::QW-1:0]  dividend,
	input  logic [DVW-1:0]              divisor,
	output logic                        done,
	output logic [vrb_pkg::QW-1:0]      quotient,
	output logic [DVW-1:0]              remainder
);
	import vrb_pkg::*;

	localparam int CW = $clog2(QW);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dsr_q;
	logic [QW-1:0]  low_q;
	logic [DVW:0]   trial;
	logic [DVW:0]   diff;
	logic           ge;

	// the caller guarantees dividend / divisor < 2**QW, so the top part starts below divisor
	always_comb begin
		trial = {rem_q, low_q[QW-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DVW+QW-1:QW];
			low_q <= dividend[QW-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
			low_q <= {low_q[QW-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = low_q;
	assign remainder = rem_q;

endmodule
